/* src/csfd_pkg.sv */
// Package for the checksummed frame deframer: status codes, register
// indexes, frame layout constants and the result beat type.
// No dependencies.
package csfd_pkg;

   // Header layout: two SOF bytes, length, type, destination, source, two sequence bytes.
   localparam logic [8:0] HeaderLen = 9'd8;

   // Register reset values.
   localparam logic [15:0] SofReset    = 16'h55AA;
   localparam logic [7:0]  MaxLenReset = 8'd64;
   localparam logic [7:0]  TypeLimReset = 8'd4;

   // Configuration register indexes.
   localparam logic [1:0] CsrSofValue  = 2'd0;
   localparam logic [1:0] CsrMaxLen    = 2'd1;
   localparam logic [1:0] CsrTypeLimit = 2'd2;

   // Header byte positions of each field.
   localparam logic [8:0] PosSofHigh = 9'd0;
   localparam logic [8:0] PosSofLow  = 9'd1;
   localparam logic [8:0] PosLength  = 9'd2;
   localparam logic [8:0] PosType    = 9'd3;
   localparam logic [8:0] PosDest    = 9'd4;
   localparam logic [8:0] PosSource  = 9'd5;
   localparam logic [8:0] PosSeqHigh = 9'd6;
   localparam logic [8:0] PosSeqLow  = 9'd7;

   // Result kinds.
   localparam logic KindPayload = 1'b0;
   localparam logic KindStatus  = 1'b1;

   typedef enum logic [2:0] {
      StatOk        = 3'd0,
      StatBadSof    = 3'd1,
      StatBadLength = 3'd2,
      StatBadType   = 3'd3,
      StatBadSum    = 3'd4,
      StatTruncated = 3'd5
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [7:0]  frame_type;
      logic [7:0]  dest_addr;
      logic [7:0]  source_addr;
      logic [15:0] seq_number;
      logic [7:0]  payload_count;
      logic [15:0] computed_sum;
      logic [15:0] received_sum;
   } rsp_type;

endpackage

/* src/checksummed_frame_deframer_top.sv */
// Top level of the checksummed frame deframer: byte parser, result register
// and skid stage. Depends on csfd_pkg.
//
//   channel | direction | handshake          | beat
//   req_    | in        | req_valid/req_stall | one stream byte and a buffer-end flag
//   rsp_    | out       | rsp_valid/rsp_stall | one payload byte or one frame status
//   csr_    | in        | csr_valid/csr_ready | register index and write data
//
// Each byte is parsed in the cycle it is accepted and its result, if any, is
// registered; one byte can be accepted every cycle while req_stall is low.
// The rate is set by the single parse stage, a position compare and a 16-bit add.
// A skid stage holds one result while the output register is stalled; req_stall
// rises only while that stage is full. Reset is synchronous and returns the parser
// to hunting for SOF with the registers at their reset values.
module checksummed_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_frame_type,
   output logic [7:0]  rsp_dest_addr,
   output logic [7:0]  rsp_source_addr,
   output logic [15:0] rsp_seq_number,
   output logic [7:0]  rsp_payload_count,
   output logic [15:0] rsp_computed_sum,
   output logic [15:0] rsp_received_sum,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [15:0] sof_value_ff;
   logic [7:0]  max_len_ff;
   logic [7:0]  type_limit_ff;

   // Parser state.
   logic [8:0]  pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  sof_hi_ff, sof_hi_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  source_ff, source_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  chk_hi_ff, chk_hi_in;

   // Output side.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   csfd_pkg::rsp_type     rsp_ff, rsp_in;
   csfd_pkg::rsp_type     skid_ff, skid_in;
   csfd_pkg::rsp_type     res;
   logic                  has_res;

   logic        req_acc;
   logic        out_take;
   logic        first;
   logic [15:0] cur_sum;
   logic [7:0]  cur_len;
   logic [8:0]  chk_pos;
   logic [15:0] sum_add;
   logic [15:0] recv_word;
   logic        is_payload;
   logic        done;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid & ~skid_valid_ff;
   assign out_take  = rsp_valid_ff & ~rsp_stall;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         sof_value_ff  <= csfd_pkg::SofReset;
         max_len_ff    <= csfd_pkg::MaxLenReset;
         type_limit_ff <= csfd_pkg::TypeLimReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            csfd_pkg::CsrSofValue:  sof_value_ff  <= csr_wdata;
            csfd_pkg::CsrMaxLen:    max_len_ff    <= csr_wdata[7:0];
            csfd_pkg::CsrTypeLimit: type_limit_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Byte parser. At the hunting position the frame state reads as cleared.
   always_comb begin
      first      = (pos_ff == 9'd0);
      cur_sum    = first ? 16'd0 : sum_ff;
      cur_len    = first ? 8'd0 : len_ff;
      sof_hi_in  = first ? 8'd0 : sof_hi_ff;
      len_in     = cur_len;
      type_in    = first ? 8'd0 : type_ff;
      dest_in    = first ? 8'd0 : dest_ff;
      source_in  = first ? 8'd0 : source_ff;
      seq_in     = first ? 16'd0 : seq_ff;
      chk_hi_in  = first ? 8'd0 : chk_hi_ff;
      chk_pos    = csfd_pkg::HeaderLen + {1'b0, cur_len};
      sum_add    = cur_sum + {8'd0, req_data_byte};
      sum_in     = cur_sum;
      recv_word  = {chk_hi_in, req_data_byte};
      is_payload = 1'b0;
      done       = 1'b0;
      has_res    = 1'b0;
      pos_in     = pos_ff + 9'd1;

      res               = '0;
      res.kind          = csfd_pkg::KindStatus;
      res.status        = csfd_pkg::StatOk;

      // Store and sum the byte according to its place in the frame.
      if (pos_ff < csfd_pkg::HeaderLen) begin
         sum_in = sum_add;
         case (pos_ff)
            csfd_pkg::PosSofHigh: sof_hi_in = req_data_byte;
            csfd_pkg::PosLength:  len_in    = req_data_byte;
            csfd_pkg::PosType:    type_in   = req_data_byte;
            csfd_pkg::PosDest:    dest_in   = req_data_byte;
            csfd_pkg::PosSource:  source_in = req_data_byte;
            csfd_pkg::PosSeqHigh: seq_in    = {req_data_byte, 8'd0};
            csfd_pkg::PosSeqLow:  seq_in    = {seq_in[15:8], req_data_byte};
            default: ;
         endcase
      end else if (pos_ff < chk_pos) begin
         sum_in     = sum_add;
         is_payload = 1'b1;
      end else if (pos_ff == chk_pos) begin
         chk_hi_in = req_data_byte;
      end else begin
         // Final checksum byte: the frame completes even at a buffer end.
         done             = 1'b1;
         has_res          = 1'b1;
         res.received_sum = recv_word;
         res.status       = (recv_word == cur_sum) ? csfd_pkg::StatOk
                                                   : csfd_pkg::StatBadSum;
      end

      // Truncation and header checks, in order of precedence.
      if (!done) begin
         if (req_buffer_end) begin
            has_res    = 1'b1;
            res.status = csfd_pkg::StatTruncated;
         end else if (pos_ff == csfd_pkg::PosSofLow &&
                      {sof_hi_in, req_data_byte} != sof_value_ff) begin
            has_res    = 1'b1;
            res.status = csfd_pkg::StatBadSof;
         end else if (pos_ff == csfd_pkg::PosLength && req_data_byte > max_len_ff) begin
            has_res    = 1'b1;
            res.status = csfd_pkg::StatBadLength;
         end else if (pos_ff == csfd_pkg::PosType && req_data_byte >= type_limit_ff) begin
            has_res    = 1'b1;
            res.status = csfd_pkg::StatBadType;
         end
      end

      // Status beats carry the header fields; any status ends the frame.
      if (has_res) begin
         pos_in            = 9'd0;
         res.frame_type    = type_in;
         res.dest_addr     = dest_in;
         res.source_addr   = source_in;
         res.seq_number    = seq_in;
         res.payload_count = len_in;
         res.computed_sum  = sum_in;
      end else if (is_payload) begin
         has_res          = 1'b1;
         res              = '0;
         res.kind         = csfd_pkg::KindPayload;
         res.payload_byte = req_data_byte;
      end
   end

   // Result register and skid stage.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_acc && has_res) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 9'd0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (req_acc) begin
            pos_ff <= pos_in;
         end
      end
   end

   // Frame fields and result payloads.
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
      if (req_acc) begin
         sum_ff    <= sum_in;
         sof_hi_ff <= sof_hi_in;
         len_ff    <= len_in;
         type_ff   <= type_in;
         dest_ff   <= dest_in;
         source_ff <= source_in;
         seq_ff    <= seq_in;
         chk_hi_ff <= chk_hi_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_payload_byte  = rsp_ff.payload_byte;
   assign rsp_status        = rsp_ff.status;
   assign rsp_frame_type    = rsp_ff.frame_type;
   assign rsp_dest_addr     = rsp_ff.dest_addr;
   assign rsp_source_addr   = rsp_ff.source_addr;
   assign rsp_seq_number    = rsp_ff.seq_number;
   assign rsp_payload_count = rsp_ff.payload_count;
   assign rsp_computed_sum  = rsp_ff.computed_sum;
   assign rsp_received_sum  = rsp_ff.received_sum;

   // The skid stage only fills behind a held output beat.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage full while output register empty");

   // Inside a frame the position never passes the final checksum byte.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 9'd0) |-> (pos_ff <= csfd_pkg::HeaderLen + {1'b0, len_ff} + 9'd1))
      else $error("byte position beyond end of frame");

   // Every status beat sends the parser back to hunting for SOF.
   a_status_resets: assert property (@(posedge clock) disable iff (reset)
      (req_acc && has_res && res.kind == csfd_pkg::KindStatus) |=> (pos_ff == 9'd0))
      else $error("parser did not return to hunting after a status beat");

endmodule
